FILE: src/jse_pkg.sv
// jse_pkg: types, character constants and escape helpers for the JSON string escaper.
// No dependencies; imported by every module of the block.
package jse_pkg;

    localparam int CAP_W     = 17;    // capacity register and write offset width
    localparam int SEQ_MAX   = 6;     // longest escape sequence (\u00XX)
    localparam int RES_MAX   = 8;     // most results one item can cause
    localparam int QDEPTH    = 2;     // descriptor queue depth

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5c;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_B  = 8'h62;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_LOW_N  = 8'h6e;
    localparam logic [7:0] CHAR_LOW_R  = 8'h72;
    localparam logic [7:0] CHAR_LOW_T  = 8'h74;
    localparam logic [7:0] CHAR_LOW_U  = 8'h75;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_LF  = 8'h0a;
    localparam logic [7:0] CTRL_FF  = 8'h0c;
    localparam logic [7:0] CTRL_CR  = 8'h0d;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       string_start;
        logic       string_end;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       buffer_full;
        logic       last_of_item;
    } out_item_t;

    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] seq;
        logic [2:0]              len;
    } esc_t;

    // One item's worth of results: n_bytes written bytes, then an error result if err.
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [3:0]              n_bytes;
        logic                    err;
    } desc_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
            r = CHAR_ZERO + {4'b0, n};
        else
            r = CHAR_LOW_A + {4'b0, n} - 8'd10;
        return r;
    endfunction

    function automatic esc_t escape_byte(input logic [7:0] c);
        esc_t       e;
        logic [7:0] sc;
        e  = '0;
        sc = 8'h00;
        unique case (c)
            CTRL_BS:  sc = CHAR_LOW_B;
            CTRL_FF:  sc = CHAR_LOW_F;
            CTRL_LF:  sc = CHAR_LOW_N;
            CTRL_CR:  sc = CHAR_LOW_R;
            CTRL_TAB: sc = CHAR_LOW_T;
            default:  sc = 8'h00;
        endcase
        priority if (c == CHAR_QUOTE || c == CHAR_BSLASH)
        begin
            e.seq[0] = CHAR_BSLASH;
            e.seq[1] = c;
            e.len    = 3'd2;
        end
        else if (c >= CTRL_LIMIT)
        begin
            e.seq[0] = c;
            e.len    = 3'd1;
        end
        else if (sc != 8'h00)
        begin
            e.seq[0] = CHAR_BSLASH;
            e.seq[1] = sc;
            e.len    = 3'd2;
        end
        else
        begin
            e.seq[0] = CHAR_BSLASH;
            e.seq[1] = CHAR_LOW_U;
            e.seq[2] = CHAR_ZERO;
            e.seq[3] = CHAR_ZERO;
            e.seq[4] = hex_digit(c[7:4] & NIBBLE_MASK);
            e.seq[5] = hex_digit(c[3:0] & NIBBLE_MASK);
            e.len    = 3'd6;
        end
        return e;
    endfunction

endpackage

FILE: src/jse_front.sv
// jse_front: accepts items, checks capacity and builds the result descriptor per item.
// Holds capacity, write offset and sticky error. Depends on jse_pkg.
module jse_front
    import jse_pkg::*;
#(
    parameter int MAX_CAPACITY = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  in_item_t         item,
    input  logic             cap_we,
    input  logic [CAP_W-1:0] cap_wdata,
    output logic             desc_push,
    output desc_t            desc
);

    localparam int CAP_TOP = (1 << CAP_W) - 1;
    localparam logic [CAP_W-1:0] CAP_LIMIT =
        CAP_W'((MAX_CAPACITY > CAP_TOP) ? CAP_TOP : MAX_CAPACITY);
    localparam logic [CAP_W-1:0] CAP_RESET =
        CAP_W'((65536 > MAX_CAPACITY) ? MAX_CAPACITY : 65536);

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] offset_reg, offset_next;
    logic             full_error_reg, full_error_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            offset_reg     <= '0;
            full_error_reg <= 1'b0;
        end
        else
        begin
            if (cap_we)
                cap_reg <= (cap_wdata > CAP_LIMIT) ? CAP_LIMIT : cap_wdata;
            if (accept)
            begin
                offset_reg     <= offset_next;
                full_error_reg <= full_error_next;
            end
        end
    end

    always_comb
    begin
        logic [CAP_W-1:0] base;
        logic             err_in;
        esc_t             esc;
        logic [2:0]       blen;
        logic [CAP_W:0]   sum1, sum2, sum3, capx;
        logic             ok1, ok2, ok3;
        logic             ws, wb, we;
        logic [3:0]       lb, j, n;

        base   = item.restart ? '0 : offset_reg;
        err_in = full_error_reg & ~item.restart;
        esc    = escape_byte(item.data_byte);
        blen   = item.has_byte ? esc.len : 3'd0;
        capx   = {1'b0, cap_reg};

        // Offsets after the opening quote, the byte's sequence and the closing quote
        sum1 = {1'b0, base} + (CAP_W+1)'(item.string_start);
        sum2 = sum1 + (CAP_W+1)'(blen);
        sum3 = sum2 + (CAP_W+1)'(item.string_end);

        ok1 = ~item.string_start | (sum1 <= capx);
        ok2 = ok1 & (~item.has_byte | (sum2 <= capx));
        ok3 = ok2 & (~item.string_end | (sum3 <= capx));

        ws = ~err_in & item.string_start & ok1;
        wb = ~err_in & item.has_byte & ok2;
        we = ~err_in & item.string_end & ok3;

        lb = wb ? {1'b0, esc.len} : 4'd0;
        n  = 4'(ws) + lb + 4'(we);

        desc.err     = err_in | ~ok3;
        desc.n_bytes = n;
        for (int i = 0; i < RES_MAX; i++)
        begin
            j = 4'(i) - 4'(ws);
            if (ws && i == 0)
                desc.bytes[i] = CHAR_QUOTE;
            else if (wb && j < lb)
                desc.bytes[i] = esc.seq[j[2:0]];
            else if (we && j == lb)
                desc.bytes[i] = CHAR_QUOTE;
            else
                desc.bytes[i] = 8'h00;
        end

        offset_next     = base + CAP_W'(n);
        full_error_next = desc.err;
        desc_push       = accept & (desc.err | (n != 4'd0));
    end

endmodule

FILE: src/jse_fifo.sv
// jse_fifo: short descriptor queue between the front and back ends.
// Depends on jse_pkg for desc_t and QDEPTH.
module jse_fifo
    import jse_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  desc_t wr_data,
    input  logic  rd_en,
    output desc_t rd_data,
    output logic  q_full,
    output logic  q_empty
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    desc_t           mem_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_wr, do_rd;

    assign q_full  = (count_reg == CW'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en & ~q_full;
    assign do_rd   = rd_en & ~q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: src/jse_back.sv
// jse_back: plays one descriptor out as a run of result transactions.
// Depends on jse_pkg.
module jse_back
    import jse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  desc_t     q_data,
    input  logic      q_empty,
    output logic      q_pop,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    desc_t      cur_reg;
    logic       cur_valid_reg;
    logic [2:0] pos_reg;
    logic [3:0] total;
    logic       is_last, finishing, load;

    assign total     = cur_reg.n_bytes + 4'(cur_reg.err);
    assign is_last   = ({1'b0, pos_reg} == total - 4'd1);
    assign finishing = cur_valid_reg & pop & is_last;
    assign load      = ~cur_valid_reg | finishing;
    assign q_pop     = load & ~q_empty;
    assign empty     = ~cur_valid_reg;

    always_comb
    begin
        if ({1'b0, pos_reg} < cur_reg.n_bytes)
        begin
            result.out_byte    = cur_reg.bytes[pos_reg];
            result.byte_valid  = 1'b1;
            result.buffer_full = 1'b0;
        end
        else
        begin
            result.out_byte    = 8'h00;
            result.byte_valid  = 1'b0;
            result.buffer_full = 1'b1;
        end
        result.last_of_item = is_last;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else if (load)
        begin
            cur_valid_reg <= ~q_empty;
            pos_reg       <= '0;
        end
        else if (pop)
            pos_reg <= pos_reg + 3'd1;
    end

endmodule

FILE: src/json_string_escaper.sv
// json_string_escaper: JSON string escaping into a bounded output buffer.
// Path: an accepted item that yields results is written to the queue as a descriptor,
//   which the back end then loads into its current register to drive the result ports.
// Throughput: one item per cycle while each item yields at most one result and pop is
//   held high; otherwise one result per cycle while pop is high (back-end serialiser).
// Reset (rst_n, async, active low): offset and sticky error cleared, queue emptied,
//   capacity set to 65536 saturated to MAX_CAPACITY. Depends on jse_pkg.
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int MAX_CAPACITY = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    // input side: a transaction completes when push is high and full is low
    input  logic             push,
    output logic             full,
    input  in_item_t         item,
    // result side: a transaction completes when pop is high and empty is low
    input  logic             pop,
    output logic             empty,
    output out_item_t        result,
    // capacity register, written whenever cap_we is high
    input  logic             cap_we,
    input  logic [CAP_W-1:0] cap_wdata
);

    // Front end: one item per cycle (while the queue is not full) is classified, checked
    // against capacity and turned into a descriptor holding every byte it writes plus an
    // error flag. Back end: descriptors are played out one result per cycle while pop
    // is high. The queue in between decouples the two so an expanding escape only stalls
    // the input once the queue has filled.

    logic  accept;
    logic  desc_push;
    desc_t desc;
    desc_t q_data;
    logic  q_pop;
    logic  q_empty;

    assign accept = push & ~full;

    jse_front #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cap_we    (cap_we),
        .cap_wdata (cap_wdata),
        .desc_push (desc_push),
        .desc      (desc)
    );

    jse_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data (desc),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_full  (full),
        .q_empty (q_empty)
    );

    jse_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for json_string_escaper (JSON string escaping, bounded buffer).
// Holds a scoreboard class with its own escaping predictor; depends on jse_pkg and the block.
module tb_top
    import jse_pkg::*;
();

    localparam int MAX_CAP        = 65536;  // matches the block's default MAX_CAPACITY
    localparam int SETTLE_CYCLES  = 12;     // pipeline latency plus a full serialiser burst
    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no transaction on either side
    localparam int N_PHASES       = 13;

    // Capacities for the random phases: saturation, tiny buffers, exact fits and the top end
    localparam logic [CAP_W-1:0] PHASE_CAPS [N_PHASES] = '{
        17'd131071, 17'd1, 17'd2, 17'd7, 17'd6, 17'd8, 17'd13,
        17'd40, 17'd65535, 17'd100, 17'd3, 17'd65537, 17'd65536
    };

    // ------------------------------------------------------------------
    // Scoreboard: predicts the escaped byte stream and checks the results
    // ------------------------------------------------------------------
    class escape_scoreboard;
        int unsigned capacity;      // last value written to the capacity register
        int unsigned offset;        // bytes written into the buffer so far
        bit          sticky_err;    // overflow seen and not yet cleared by a restart
        out_item_t   expected_q[$];
        out_item_t   item_res[$];   // results of the item being predicted
        int          n_errors;

        function new();
            capacity   = MAX_CAP;
            offset     = 0;
            sticky_err = 1'b0;
            n_errors   = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] v);
            capacity = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Escaped form of one raw byte; returns the sequence length
        function int escape_char(logic [7:0] c, output logic [SEQ_MAX-1:0][7:0] seq);
            logic [7:0] short_code;
            seq = '0;
            case (c)
                CTRL_BS:  short_code = CHAR_LOW_B;
                CTRL_FF:  short_code = CHAR_LOW_F;
                CTRL_LF:  short_code = CHAR_LOW_N;
                CTRL_CR:  short_code = CHAR_LOW_R;
                CTRL_TAB: short_code = CHAR_LOW_T;
                default:  short_code = 8'h00;
            endcase
            if (c == CHAR_QUOTE || c == CHAR_BSLASH)
            begin
                seq[0] = CHAR_BSLASH;
                seq[1] = c;
                return 2;
            end
            if (c >= CTRL_LIMIT)
            begin
                seq[0] = c;
                return 1;
            end
            if (short_code != 8'h00)
            begin
                seq[0] = CHAR_BSLASH;
                seq[1] = short_code;
                return 2;
            end
            // remaining control bytes: \u00 and two lowercase hex digits
            seq[0] = CHAR_BSLASH;
            seq[1] = CHAR_LOW_U;
            seq[2] = CHAR_ZERO;
            seq[3] = CHAR_ZERO;
            seq[4] = (c[7:4] < 4'd10) ? CHAR_ZERO + {4'b0, c[7:4]}
                                      : CHAR_LOW_A + {4'b0, c[7:4]} - 8'd10;
            seq[5] = (c[3:0] < 4'd10) ? CHAR_ZERO + {4'b0, c[3:0]}
                                      : CHAR_LOW_A + {4'b0, c[3:0]} - 8'd10;
            return 6;
        endfunction

        // A sequence goes into the buffer whole or not at all
        function bit write_seq(logic [SEQ_MAX-1:0][7:0] seq, int len);
            int unsigned lim;
            int          i;
            out_item_t   r;
            lim = (capacity > MAX_CAP) ? MAX_CAP : capacity;
            if (offset + len > lim)
                return 1'b0;
            for (i = 0; i < len; i++)
            begin
                r              = '0;
                r.out_byte     = seq[i];
                r.byte_valid   = 1'b1;
                item_res.push_back(r);
            end
            offset += len;
            return 1'b1;
        endfunction

        // Called for every accepted input transaction
        function void note_item(in_item_t it);
            logic [SEQ_MAX-1:0][7:0] seq;
            logic [SEQ_MAX-1:0][7:0] quote;
            int        len;
            bit        ok;
            out_item_t r;
            quote    = '0;
            quote[0] = CHAR_QUOTE;
            item_res.delete();
            ok = 1'b1;
            if (it.restart)
            begin
                offset     = 0;
                sticky_err = 1'b0;
            end
            if (sticky_err)
                ok = 1'b0;
            else
            begin
                if (ok && it.string_start)
                    ok = write_seq(quote, 1);
                if (ok && it.has_byte)
                begin
                    len = escape_char(it.data_byte, seq);
                    ok  = write_seq(seq, len);
                end
                if (ok && it.string_end)
                    ok = write_seq(quote, 1);
            end
            if (!ok)
            begin
                sticky_err    = 1'b1;
                r             = '0;
                r.buffer_full = 1'b1;
                item_res.push_back(r);
            end
            if (item_res.size() > 0)
            begin
                r = item_res.pop_back();
                r.last_of_item = 1'b1;
                item_res.push_back(r);
            end
            foreach (item_res[k])
                expected_q.push_back(item_res[k]);
        endfunction

        // Called for every accepted result transaction
        function void check_result(out_item_t got);
            out_item_t exp;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: out_byte %h byte_valid %b buffer_full %b last %b",
                       got.out_byte, got.byte_valid, got.buffer_full, got.last_of_item);
                n_errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.out_byte !== exp.out_byte)
            begin
                $error("out_byte: expected %h, actual %h", exp.out_byte, got.out_byte);
                n_errors++;
            end
            if (got.byte_valid !== exp.byte_valid)
            begin
                $error("byte_valid: expected %b, actual %b", exp.byte_valid, got.byte_valid);
                n_errors++;
            end
            if (got.buffer_full !== exp.buffer_full)
            begin
                $error("buffer_full: expected %b, actual %b", exp.buffer_full, got.buffer_full);
                n_errors++;
            end
            if (got.last_of_item !== exp.last_of_item)
            begin
                $error("last_of_item: expected %b, actual %b",
                       exp.last_of_item, got.last_of_item);
                n_errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block and its stimulus signals
    // ------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    in_item_t         item;
    logic             pop;
    logic             empty;
    out_item_t        result;
    logic             cap_we;
    logic [CAP_W-1:0] cap_wdata;

    escape_scoreboard sb;

    int in_idle_pct  = 34;   // chance per try of an idle cycle on the input side
    int out_idle_pct = 34;   // chance per cycle of a pop stall
    int stall_cycles = 0;

    // generator state for well-formed strings
    bit in_str       = 1'b0;
    int str_left     = 0;

    json_string_escaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cap_we    (cap_we),
        .cap_wdata (cap_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: ends the run if neither side completes a transaction for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: random pop stalls, every accepted result goes to the scoreboard
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(99) >= out_idle_pct);
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(result);
        end
    end

    function automatic in_item_t mk_item(logic [7:0] d, logic h, logic s, logic e, logic r);
        in_item_t it;
        it.data_byte    = d;
        it.has_byte     = h;
        it.string_start = s;
        it.string_end   = e;
        it.restart      = r;
        return it;
    endfunction

    // Weighted towards the bytes that need escaping
    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return 8'($urandom_range(31));
        if (pick < 40)
            return ($urandom_range(1) != 0) ? CHAR_QUOTE : CHAR_BSLASH;
        if (pick < 80)
            return 8'($urandom_range(126, 32));
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed strings (restart, start quote, bytes, end quote), some noise
    task automatic next_random_item(output in_item_t it);
        it = '0;
        if ($urandom_range(99) < 20)
        begin
            it = mk_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            return;
        end
        if (!in_str)
        begin
            in_str          = 1'b1;
            str_left        = $urandom_range(6);
            it.string_start = 1'b1;
            it.restart      = ($urandom_range(99) < 30);
        end
        if (str_left == 0)
        begin
            // empty string, or the closing quote on its own
            it.string_end = 1'b1;
            in_str        = 1'b0;
            return;
        end
        it.has_byte  = 1'b1;
        it.data_byte = random_char();
        str_left--;
        if (str_left == 0 && $urandom_range(99) < 80)
        begin
            it.string_end = 1'b1;
            in_str        = 1'b0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    // push is left high so back-to-back items do not see a glitch.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < in_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_item(it);
        @(negedge clk);
    endtask

    // Waits for every expected result, then lets the block settle before the next step
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only ever called with the block idle
    task automatic write_capacity(input logic [CAP_W-1:0] v);
        cap_we    <= 1'b1;
        cap_wdata <= v;
        @(negedge clk);
        cap_we    <= 1'b0;
        sb.set_capacity(v);
    endtask

    initial
    begin
        in_item_t it;
        int       p;
        int       n;
        int       n_items;

        sb        = new();
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cap_we    = 1'b0;
        cap_wdata = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every escape class and the edges of the byte range, large buffer
        write_capacity(17'd65536);
        send_item(mk_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));        // empty string
        send_item(mk_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));        // nothing requested
        send_item(mk_item(8'h41, 1'b1, 1'b1, 1'b0, 1'b0));
        send_item(mk_item(CHAR_QUOTE, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(CHAR_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(CTRL_BS, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(CTRL_FF, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(CTRL_LF, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(CTRL_CR, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(CTRL_TAB, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(8'h1f, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(8'h20, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(8'h7f, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(8'h80, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(8'hff, 1'b1, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(8'h01, 1'b1, 1'b1, 1'b1, 1'b0));        // longest item: 8 bytes
        send_item(mk_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b1));        // restart alone
        send_item(mk_item(8'h0b, 1'b1, 1'b1, 1'b0, 1'b1));
        send_item(mk_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0));        // closing quote only
        drain();

        // Zero capacity: overflow, sticky error, restart clearing it
        write_capacity(17'd0);
        send_item(mk_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        send_item(mk_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));        // error still pending
        send_item(mk_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b1));        // cleared, nothing to do
        send_item(mk_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b1));
        drain();

        // Exact fit of the longest item, then one byte too many
        write_capacity(17'd8);
        send_item(mk_item(8'h01, 1'b1, 1'b1, 1'b1, 1'b1));
        send_item(mk_item(8'h62, 1'b1, 1'b0, 1'b0, 1'b0));
        drain();

        // Random phases; offset is carried across capacity changes, so a shrunken
        // buffer can sit below the current offset. The first phase runs flat out.
        for (p = 0; p < N_PHASES; p++)
        begin
            in_idle_pct  = (p == 0) ? 0 : 34;
            out_idle_pct = (p == 0) ? 0 : 34;
            n_items      = (p == 0) ? 40 : 11;
            write_capacity(PHASE_CAPS[p]);
            for (n = 0; n < n_items; n++)
            begin
                next_random_item(it);
                send_item(it);
            end
            drain();
        end

        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
